[rtl/trpd_pkg.sv]
// ----------------------------------------------------------------------------
// trpd_pkg
// Shared types and constants for the run-length pixel stream decoder.
// ----------------------------------------------------------------------------
package trpd_pkg;

  // Pixel size selected by the depth_mode register.
  typedef enum logic [1:0] {
    DEPTH_8   = 2'd0,
    DEPTH_555 = 2'd1,
    DEPTH_24  = 2'd2,
    DEPTH_32  = 2'd3
  } depth_t;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TOTAL = 1'b1;

  localparam depth_t      DEPTH_RESET = DEPTH_24;
  localparam logic [31:0] TOTAL_RESET = 32'd1;

  localparam logic [6:0] HDR_COUNT_MASK = 7'h7F;
  localparam int         HDR_RUN_BIT    = 7;

endpackage

[rtl/tga_rle_pixel_decoder_unit.sv]
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit
// Decodes a run-length coded pixel byte stream into pixels with repeat counts.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid / in_stall  in_byte[7:0]
//  out_     output     out_valid/out_stall  out_chan0..3[7:0], out_repeat_count,
//                                           out_image_done
//  cfg_     input      cfg_valid/cfg_ready  cfg_index[0], cfg_data[31:0]
//
// One byte is accepted per cycle unless stalled. A header byte gives no request on
// the output; the last byte of a pixel gives one request, registered, visible the
// next cycle. Throughput is set by the single output register: while it holds a
// request that is stalled, in_stall is raised. Reset (rst_n low, synchronous)
// returns the decoder to wait for a header, depth 24 bit and a pixel total of 1.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_unit
  import trpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_chan0,
  output logic [7:0]            out_chan1,
  output logic [7:0]            out_chan2,
  output logic [7:0]            out_chan3,
  output logic [7:0]            out_repeat_count,
  output logic                  out_image_done,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  depth_t      depth_mode_r;
  logic [31:0] pixel_total_r;

  logic        expect_header_r, expect_header_nxt;
  logic        run_packet_r, run_packet_nxt;
  logic [7:0]  packet_left_r, packet_left_nxt;
  logic [1:0]  byte_idx_r, byte_idx_nxt;
  logic [31:0] assembly_r, assembly_nxt;
  logic [31:0] decoded_r, decoded_nxt;

  logic        out_valid_r;
  logic [7:0]  chan0_r, chan1_r, chan2_r, chan3_r, repeat_count_r;
  logic        image_done_r;

  logic        in_fire, out_fire;
  logic        total_reached;
  logic [31:0] remaining;
  logic [7:0]  hdr_count, hdr_clamped;
  logic        pix_done;
  logic [31:0] pix_value;
  logic [7:0]  left_eff, rep;
  logic [32:0] done_at;
  logic        done;
  logic [7:0]  c0, c1, c2, c3;

  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_chan0        = chan0_r;
  assign out_chan1        = chan1_r;
  assign out_chan2        = chan2_r;
  assign out_chan3        = chan3_r;
  assign out_repeat_count = repeat_count_r;
  assign out_image_done   = image_done_r;

  // Pixels still owed to the image; once the total is reached one more is allowed.
  assign total_reached = decoded_r >= pixel_total_r;
  assign remaining     = total_reached ? 32'd1 : (pixel_total_r - decoded_r);
  assign hdr_count     = {1'b0, in_byte[6:0] & HDR_COUNT_MASK} + 8'd1;
  assign hdr_clamped   = ({24'd0, hdr_count} > remaining) ? remaining[7:0] : hdr_count;

  // A byte index past the current pixel size also completes the pixel.
  assign pix_done  = !(byte_idx_r < depth_mode_r);
  assign pix_value = assembly_r | ({24'd0, in_byte} << {byte_idx_r, 3'b000});

  assign left_eff = (packet_left_r == 8'd0) ? 8'd1 : packet_left_r;
  assign rep      = run_packet_r ? left_eff : 8'd1;
  assign done_at  = {1'b0, decoded_r} + {25'd0, rep};
  assign done     = total_reached || (done_at >= {1'b0, pixel_total_r});

  always_comb begin
    c3 = 8'd0;
    unique case (depth_mode_r)
      DEPTH_8: begin
        c0 = pix_value[7:0];
        c1 = 8'd0;
        c2 = 8'd0;
      end
      DEPTH_555: begin
        c0 = {pix_value[4:0], 3'b000};
        c1 = {pix_value[9:5], 3'b000};
        c2 = {pix_value[14:10], 3'b000};
      end
      DEPTH_24: begin
        c0 = pix_value[7:0];
        c1 = pix_value[15:8];
        c2 = pix_value[23:16];
      end
      default: begin
        c0 = pix_value[7:0];
        c1 = pix_value[15:8];
        c2 = pix_value[23:16];
        c3 = pix_value[31:24];
      end
    endcase
  end

  always_comb begin
    expect_header_nxt = expect_header_r;
    run_packet_nxt    = run_packet_r;
    packet_left_nxt   = packet_left_r;
    byte_idx_nxt      = byte_idx_r;
    assembly_nxt      = assembly_r;
    decoded_nxt       = decoded_r;
    if (in_fire) begin
      if (expect_header_r) begin
        run_packet_nxt    = in_byte[HDR_RUN_BIT];
        packet_left_nxt   = hdr_clamped;
        byte_idx_nxt      = 2'd0;
        assembly_nxt      = 32'd0;
        expect_header_nxt = 1'b0;
      end else if (!pix_done) begin
        assembly_nxt = pix_value;
        byte_idx_nxt = byte_idx_r + 2'd1;
      end else begin
        byte_idx_nxt    = 2'd0;
        assembly_nxt    = 32'd0;
        packet_left_nxt = run_packet_r ? 8'd0 : (left_eff - 8'd1);
        if (done) begin
          decoded_nxt       = 32'd0;
          packet_left_nxt   = 8'd0;
          expect_header_nxt = 1'b1;
        end else begin
          decoded_nxt = done_at[31:0];
          if (packet_left_nxt == 8'd0) begin
            expect_header_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_mode_r    <= DEPTH_RESET;
      pixel_total_r   <= TOTAL_RESET;
      expect_header_r <= 1'b1;
      run_packet_r    <= 1'b0;
      packet_left_r   <= 8'd0;
      byte_idx_r      <= 2'd0;
      assembly_r      <= 32'd0;
      decoded_r       <= 32'd0;
      out_valid_r     <= 1'b0;
    end else begin
      expect_header_r <= expect_header_nxt;
      run_packet_r    <= run_packet_nxt;
      packet_left_r   <= packet_left_nxt;
      byte_idx_r      <= byte_idx_nxt;
      assembly_r      <= assembly_nxt;
      decoded_r       <= decoded_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DEPTH_MODE:  depth_mode_r  <= depth_t'(cfg_data[1:0]);
          CFG_PIXEL_TOTAL: pixel_total_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire && !expect_header_r && pix_done) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !expect_header_r && pix_done) begin
      chan0_r        <= c0;
      chan1_r        <= c1;
      chan2_r        <= c2;
      chan3_r        <= c3;
      repeat_count_r <= rep;
      image_done_r   <= done;
    end
  end

  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> repeat_count_r != 8'd0)
    else $error("result with zero repeat count");

  a_raw_rep_one: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !expect_header_r && pix_done && !run_packet_r)
      |=> (out_valid_r && repeat_count_r == 8'd1))
    else $error("raw pixel without repeat of one");

  a_done_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !expect_header_r && pix_done && done)
      |=> (expect_header_r && decoded_r == 32'd0 && image_done_r))
    else $error("image end did not restart the decoder");

  a_header_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && expect_header_r && !out_valid_r) |=> !out_valid_r)
    else $error("header byte produced a request");

endmodule
